@@ rtl/core/icp_pkg.sv @@
// ----------------------------------------------------------------------------
// icp_pkg
// Shared types, codes and a helper function for the Intcode step unit.
// ----------------------------------------------------------------------------
package icp_pkg;

  localparam int WORD_W = 64;
  localparam int RB_W   = 32;

  localparam logic [1:0] MODE_LOAD    = 2'd0;
  localparam logic [1:0] MODE_EXEC    = 2'd1;
  localparam logic [1:0] MODE_RESTART = 2'd2;
  localparam logic [1:0] MODE_SPARE   = 2'd3;

  localparam logic [1:0] STAT_RUN  = 2'd0;
  localparam logic [1:0] STAT_WAIT = 2'd1;
  localparam logic [1:0] STAT_HALT = 2'd2;
  localparam logic [1:0] STAT_ERR  = 2'd3;

  localparam logic [6:0] OP_ADD = 7'd1;
  localparam logic [6:0] OP_MUL = 7'd2;
  localparam logic [6:0] OP_IN  = 7'd3;
  localparam logic [6:0] OP_OUT = 7'd4;
  localparam logic [6:0] OP_JT  = 7'd5;
  localparam logic [6:0] OP_JF  = 7'd6;
  localparam logic [6:0] OP_LT  = 7'd7;
  localparam logic [6:0] OP_EQ  = 7'd8;
  localparam logic [6:0] OP_ARB = 7'd9;

  localparam logic [3:0] PM_POS = 4'd0;
  localparam logic [3:0] PM_IMM = 4'd1;
  localparam logic [3:0] PM_REL = 4'd2;

  localparam logic [63:0] HALT_WORD   = 64'd99;
  localparam logic [63:0] INSTR_LIMIT = 64'd100000;
  localparam logic signed [63:0] REL_MAX = 64'sd8589934592;
  localparam logic signed [63:0] REL_MIN = -64'sd8589934592;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_DISPATCH, S_DECODE, S_DIGIT, S_CHECK,
    S_OPLOC, S_OPADDR, S_OPVAL, S_MUL, S_EXEC, S_RESP
  } icp_state_t;

  typedef enum logic [3:0] {
    CMD_NONE, CMD_CLEAR, CMD_ACCEPT, CMD_DISPATCH, CMD_DECODE, CMD_DIGIT,
    CMD_CHECK, CMD_OPLOC, CMD_OPADDR, CMD_OPVAL, CMD_MUL, CMD_EXEC
  } icp_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic finish;
    logic digit_last;
    logic opnd_last;
    logic is_mul;
    logic mul_last;
  } icp_stat_t;

  function automatic logic [1:0] param_count(input logic [6:0] op);
    logic [1:0] n;
    case (op)
      OP_ADD, OP_MUL, OP_LT, OP_EQ: n = 2'd3;
      OP_JT, OP_JF:                 n = 2'd2;
      OP_IN, OP_OUT, OP_ARB:        n = 2'd1;
      default:                      n = 2'd0;
    endcase
    return n;
  endfunction

endpackage

@@ rtl/core/icp_if.sv @@
// ----------------------------------------------------------------------------
// icp_in_if / icp_out_if
// Valid/ready channels for command words and result words.
// ----------------------------------------------------------------------------
interface icp_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         mode;
  logic [11:0]        address;
  logic signed [63:0] data;
  logic               input_valid;
  logic signed [63:0] input_value;

  modport source(output valid, mode, address, data, input_valid, input_value,
                 input ready);
  modport sink(input valid, mode, address, data, input_valid, input_value,
               output ready);
endinterface

interface icp_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic               input_taken;
  logic               out_valid;
  logic signed [63:0] out_value;
  logic [11:0]        next_pc;

  modport source(output valid, status, input_taken, out_valid, out_value, next_pc,
                 input ready);
  modport sink(input valid, status, input_taken, out_valid, out_value, next_pc,
               output ready);
endinterface

@@ rtl/core/intcode_processor_step_unit.sv @@
// Flow: load, restart and blocked words pass through dispatch to response; a halt
// also passes decode; an executed instruction passes dispatch, decode, the digits,
// check, operand fetch per operand, multiply for MUL, execute and response. One word
// at a time; the next accept comes in the cycle after the result is taken. The word
// memory has one read port, read twice per operand. Reset: synchronous active-low;
// afterwards a clearing pass zeroes the word memory while in_ch.ready stays low.
// ----------------------------------------------------------------------------
// intcode_processor_step_unit
// Intcode machine: loads program words, executes one instruction per word,
// or restarts; reports status, input use, output and next pc.
// ----------------------------------------------------------------------------
module intcode_processor_step_unit #(
  parameter int MEM_WORDS = 4096
) (
  input  logic      clk,
  input  logic      rst_n,
  icp_in_if.sink    in_ch,
  icp_out_if.source out_ch
);
  import icp_pkg::*;

  icp_cmd_t  cmd;
  icp_stat_t stat;
  logic [63:0] res_value;

  icp_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .stat(stat), .cmd(cmd)
  );

  icp_dpath #(.MEM_WORDS(MEM_WORDS)) u_dpath (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .stat(stat),
    .in_mode(in_ch.mode), .in_address(in_ch.address),
    .in_data(64'(in_ch.data)), .in_input_valid(in_ch.input_valid),
    .in_input_value(64'(in_ch.input_value)),
    .res_status(out_ch.status), .res_input_taken(out_ch.input_taken),
    .res_out_valid(out_ch.out_valid), .res_out_value(res_value),
    .res_next_pc(out_ch.next_pc)
  );

  assign out_ch.out_value = signed'(res_value);
endmodule

@@ rtl/core/icp_ram.sv @@
// ----------------------------------------------------------------------------
// icp_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module icp_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

@@ rtl/core/icp_ctrl.sv @@
// ----------------------------------------------------------------------------
// icp_ctrl
// Sequencer: steps the datapath through clear, dispatch, decode, digit, check,
// operand fetch, multiply, execute and response.
// ----------------------------------------------------------------------------
module icp_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  icp_pkg::icp_stat_t stat,
  output icp_pkg::icp_cmd_t  cmd
);
  import icp_pkg::*;

  icp_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLEAR:    if (stat.clr_last) state_nxt = S_IDLE;
      S_IDLE:     if (in_valid) state_nxt = S_DISPATCH;
      S_DISPATCH: state_nxt = stat.finish ? S_RESP : S_DECODE;
      S_DECODE:   state_nxt = stat.finish ? S_RESP : S_DIGIT;
      S_DIGIT:    if (stat.digit_last) state_nxt = S_CHECK;
      S_CHECK:    state_nxt = stat.finish ? S_RESP : S_OPLOC;
      S_OPLOC:    state_nxt = stat.finish ? S_RESP : S_OPADDR;
      S_OPADDR:   state_nxt = stat.finish ? S_RESP : S_OPVAL;
      S_OPVAL: begin
        if (stat.opnd_last) begin
          state_nxt = stat.is_mul ? S_MUL : S_EXEC;
        end else begin
          state_nxt = S_OPLOC;
        end
      end
      S_MUL:      if (stat.mul_last) state_nxt = S_EXEC;
      S_EXEC:     state_nxt = S_RESP;
      S_RESP:     if (out_ready) state_nxt = S_IDLE;
      default:    state_nxt = S_CLEAR;
    endcase
  end

  always_comb begin
    in_ready  = 1'b0;
    out_valid = 1'b0;
    cmd       = CMD_NONE;
    case (state_r)
      S_CLEAR:    cmd = CMD_CLEAR;
      S_IDLE: begin
        in_ready = 1'b1;
        cmd      = in_valid ? CMD_ACCEPT : CMD_NONE;
      end
      S_DISPATCH: cmd = CMD_DISPATCH;
      S_DECODE:   cmd = CMD_DECODE;
      S_DIGIT:    cmd = CMD_DIGIT;
      S_CHECK:    cmd = CMD_CHECK;
      S_OPLOC:    cmd = CMD_OPLOC;
      S_OPADDR:   cmd = CMD_OPADDR;
      S_OPVAL:    cmd = CMD_OPVAL;
      S_MUL:      cmd = CMD_MUL;
      S_EXEC:     cmd = CMD_EXEC;
      S_RESP:     out_valid = 1'b1;
      default:    cmd = CMD_NONE;
    endcase
  end
endmodule

@@ rtl/core/icp_dpath.sv @@
// ----------------------------------------------------------------------------
// icp_dpath
// Word memory, program counter, relative base, flags, decode, operand
// registers, shared 32x32 multiplier and result word register.
// ----------------------------------------------------------------------------
module icp_dpath #(
  parameter int MEM_WORDS = 4096
) (
  input  logic               clk,
  input  logic               rst_n,
  input  icp_pkg::icp_cmd_t  cmd,
  output icp_pkg::icp_stat_t stat,
  input  logic [1:0]         in_mode,
  input  logic [11:0]        in_address,
  input  logic [63:0]        in_data,
  input  logic               in_input_valid,
  input  logic [63:0]        in_input_value,
  output logic [1:0]         res_status,
  output logic               res_input_taken,
  output logic               res_out_valid,
  output logic [63:0]        res_out_value,
  output logic [11:0]        res_next_pc
);
  import icp_pkg::*;

  localparam int AW  = $clog2(MEM_WORDS);
  localparam int PCW = AW + 1;
  localparam int LW  = PCW + 1;

  // item word
  logic [1:0]  mode_r;
  logic [11:0] addr_r;
  logic [63:0] data_r;
  logic        iv_r;
  logic [63:0] ival_r;

  // machine state
  logic [PCW-1:0] pc_r, pc_nxt;
  logic [RB_W-1:0] rb_r, rb_nxt;
  logic halt_r, halt_nxt, err_r, err_nxt;
  logic [AW-1:0] clr_r, clr_nxt;
  logic [1:0] idx_r, idx_nxt;

  // instruction
  logic [6:0] op_r, op_nxt;
  logic [9:0] rest_r, rest_nxt;
  logic [3:0] md_r [1:3];
  logic [3:0] md_nxt [1:3];
  logic [AW-1:0] oa_r [1:3];
  logic [AW-1:0] oa_nxt [1:3];
  logic [63:0] val_r [1:3];
  logic [63:0] val_nxt [1:3];
  logic [63:0] acc_r, acc_nxt;

  // result word
  logic [1:0]  st_r, st_nxt;
  logic        tk_r, tk_nxt, ov_r, ov_nxt;
  logic [63:0] oval_r, oval_nxt;

  // memory port
  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [63:0]   wdata, rdata;

  icp_ram #(.WIDTH(WORD_W), .DEPTH(MEM_WORDS)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  // decode: instr % 100 and / 100 for instr below 100000
  logic [16:0] dx;
  logic [29:0] dp;
  logic [10:0] dq0;
  logic [17:0] dq100, dr0;
  logic [10:0] dq;
  logic [17:0] dr;
  // digit: rest % 10 and / 10
  logic [16:0] gp;
  logic [6:0]  gq0;
  logic [10:0] gq10, gr0;
  logic [6:0]  gq;
  logic [10:0] gr;

  always_comb begin
    dx    = rdata[16:0];
    dp    = 30'(dx) * 30'd5242;
    dq0   = dp[29:19];
    dq100 = 18'({dq0, 6'b0}) + 18'({dq0, 5'b0}) + 18'({dq0, 2'b0});
    dr0   = {1'b0, dx} - dq100;
    if (dr0 >= 18'd100) begin
      dq = dq0 + 11'd1;
      dr = dr0 - 18'd100;
    end else begin
      dq = dq0;
      dr = dr0;
    end
    gp   = 17'(rest_r) * 17'd102;
    gq0  = gp[16:10];
    gq10 = 11'({gq0, 3'b0}) + 11'({gq0, 1'b0});
    gr0  = {1'b0, rest_r} - gq10;
    if (gr0 >= 11'd10) begin
      gq = gq0 + 7'd1;
      gr = gr0 - 11'd10;
    end else begin
      gq = gq0;
      gr = gr0;
    end
  end

  logic [1:0] npar;
  logic [LW-1:0] loc;
  logic [63:0] sum;
  logic signed [63:0] raw;
  logic [31:0] ma, mb;
  logic [63:0] prod;
  logic [63:0] v1, v2;
  logic [RB_W+11:0] pc_ext;
  logic [AW+11:0] la_ext;

  assign npar   = param_count(op_r);
  assign loc    = LW'(pc_r) + LW'(idx_r);
  assign raw    = signed'(rdata);
  assign sum    = {{32{rb_r[RB_W-1]}}, rb_r} + rdata;
  assign v1     = val_r[1];
  assign v2     = val_r[2];
  assign la_ext = {{AW{1'b0}}, addr_r};
  assign prod   = 64'(ma) * 64'(mb);

  always_comb begin
    case (idx_r)
      2'd0:    begin ma = v1[31:0];  mb = v2[31:0];  end
      2'd1:    begin ma = v1[31:0];  mb = v2[63:32]; end
      default: begin ma = v1[63:32]; mb = v2[31:0];  end
    endcase
  end

  always_comb begin
    logic fail;
    logic [AW-1:0] oa;
    logic ok_md;
    pc_nxt = pc_r; rb_nxt = rb_r; halt_nxt = halt_r; err_nxt = err_r;
    clr_nxt = clr_r; idx_nxt = idx_r; op_nxt = op_r; rest_nxt = rest_r;
    md_nxt = md_r; oa_nxt = oa_r; val_nxt = val_r; acc_nxt = acc_r;
    st_nxt = st_r; tk_nxt = tk_r; ov_nxt = ov_r; oval_nxt = oval_r;
    we = 1'b0; waddr = clr_r; wdata = '0; raddr = pc_r[AW-1:0];
    stat = '0;
    fail = 1'b0;
    oa = '0;
    ok_md = 1'b1;
    stat.clr_last   = (clr_r == AW'(MEM_WORDS - 1));
    stat.digit_last = (idx_r == 2'd3);
    stat.opnd_last  = (idx_r == npar);
    stat.is_mul     = (op_r == OP_MUL);
    stat.mul_last   = (idx_r == 2'd2);
    case (cmd)
      CMD_CLEAR: begin
        we = 1'b1;
        clr_nxt = clr_r + AW'(1);
      end
      CMD_DISPATCH: begin
        tk_nxt = 1'b0; ov_nxt = 1'b0; oval_nxt = '0;
        st_nxt = err_r ? STAT_ERR : (halt_r ? STAT_HALT : STAT_RUN);
        stat.finish = 1'b1;
        case (mode_r)
          MODE_LOAD: begin
            if (32'(addr_r) < 32'(MEM_WORDS)) begin
              we = 1'b1;
              waddr = la_ext[AW-1:0];
              wdata = data_r;
            end
          end
          MODE_RESTART: begin
            pc_nxt = '0; rb_nxt = '0; halt_nxt = 1'b0; err_nxt = 1'b0;
            st_nxt = STAT_RUN;
          end
          MODE_EXEC: begin
            if (!err_r && !halt_r) begin
              if (pc_r >= PCW'(MEM_WORDS)) begin
                fail = 1'b1;
              end else begin
                stat.finish = 1'b0;
                st_nxt = STAT_RUN;
              end
            end
          end
          default: ;
        endcase
      end
      CMD_DECODE: begin
        idx_nxt = 2'd1;
        op_nxt = dr[6:0];
        rest_nxt = dq[9:0];
        if (rdata == HALT_WORD) begin
          halt_nxt = 1'b1;
          st_nxt = STAT_HALT;
          stat.finish = 1'b1;
        end else if (rdata[63] || rdata >= INSTR_LIMIT) begin
          fail = 1'b1;
        end
      end
      CMD_DIGIT: begin
        md_nxt[idx_r] = gr[3:0];
        rest_nxt = 10'(gq);
        idx_nxt = idx_r + 2'd1;
      end
      CMD_CHECK: begin
        idx_nxt = 2'd1;
        for (int k = 1; k <= 3; k++) begin
          if (2'(k) <= npar) begin
            if (md_r[k] > PM_REL) ok_md = 1'b0;
          end else if (md_r[k] != PM_POS) begin
            ok_md = 1'b0;
          end
        end
        if (op_r == 7'd0 || op_r > OP_ARB || rest_r != 10'd0 || !ok_md) fail = 1'b1;
        if ((op_r == OP_ADD || op_r == OP_MUL || op_r == OP_LT || op_r == OP_EQ) &&
            md_r[3] == PM_IMM) fail = 1'b1;
        if (op_r == OP_IN && md_r[1] == PM_IMM) fail = 1'b1;
      end
      CMD_OPLOC: begin
        raddr = loc[AW-1:0];
        if (loc >= LW'(MEM_WORDS)) fail = 1'b1;
      end
      CMD_OPADDR: begin
        case (md_r[idx_r])
          PM_POS: begin
            oa = rdata[AW-1:0];
            if (rdata[63] || rdata[62:0] >= 63'(MEM_WORDS)) fail = 1'b1;
          end
          PM_IMM: oa = loc[AW-1:0];
          default: begin
            oa = sum[AW-1:0];
            if (raw > REL_MAX || raw < REL_MIN) fail = 1'b1;
            if (sum[63] || sum[62:0] >= 63'(MEM_WORDS)) fail = 1'b1;
          end
        endcase
        raddr = oa;
        oa_nxt[idx_r] = oa;
      end
      CMD_OPVAL: begin
        val_nxt[idx_r] = rdata;
        idx_nxt = stat.opnd_last ? 2'd0 : idx_r + 2'd1;
      end
      CMD_MUL: begin
        acc_nxt = (idx_r == 2'd0) ? prod : acc_r + {prod[31:0], 32'b0};
        idx_nxt = idx_r + 2'd1;
      end
      CMD_EXEC: begin
        waddr = oa_r[3];
        case (op_r)
          OP_ADD: begin we = 1'b1; wdata = v1 + v2; pc_nxt = pc_r + PCW'(4); end
          OP_MUL: begin we = 1'b1; wdata = acc_r; pc_nxt = pc_r + PCW'(4); end
          OP_IN: begin
            if (!iv_r) begin
              st_nxt = STAT_WAIT;
            end else begin
              we = 1'b1; waddr = oa_r[1]; wdata = ival_r;
              tk_nxt = 1'b1; pc_nxt = pc_r + PCW'(2);
            end
          end
          OP_OUT: begin ov_nxt = 1'b1; oval_nxt = v1; pc_nxt = pc_r + PCW'(2); end
          OP_JT, OP_JF: begin
            if ((op_r == OP_JT) == (v1 != 64'd0)) begin
              if (v2[63] || v2[62:0] >= 63'(MEM_WORDS)) fail = 1'b1;
              else pc_nxt = v2[PCW-1:0];
            end else begin
              pc_nxt = pc_r + PCW'(3);
            end
          end
          OP_LT: begin
            we = 1'b1; wdata = {63'b0, signed'(v1) < signed'(v2)};
            pc_nxt = pc_r + PCW'(4);
          end
          OP_EQ: begin
            we = 1'b1; wdata = {63'b0, v1 == v2};
            pc_nxt = pc_r + PCW'(4);
          end
          default: begin rb_nxt = rb_r + v1[31:0]; pc_nxt = pc_r + PCW'(2); end
        endcase
      end
      default: ;
    endcase
    if (fail) begin
      stat.finish = 1'b1;
      err_nxt = 1'b1;
      st_nxt = STAT_ERR;
      we = 1'b0;
      pc_nxt = pc_r; rb_nxt = rb_r;
      tk_nxt = 1'b0; ov_nxt = 1'b0; oval_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= '0; rb_r <= '0; halt_r <= 1'b0; err_r <= 1'b0;
      clr_r <= '0; idx_r <= '0;
    end else begin
      pc_r <= pc_nxt; rb_r <= rb_nxt; halt_r <= halt_nxt; err_r <= err_nxt;
      clr_r <= clr_nxt; idx_r <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd == CMD_ACCEPT) begin
      mode_r <= in_mode; addr_r <= in_address; data_r <= in_data;
      iv_r <= in_input_valid; ival_r <= in_input_value;
    end
    op_r <= op_nxt; rest_r <= rest_nxt; md_r <= md_nxt; oa_r <= oa_nxt;
    val_r <= val_nxt; acc_r <= acc_nxt;
    st_r <= st_nxt; tk_r <= tk_nxt; ov_r <= ov_nxt; oval_r <= oval_nxt;
  end

  assign pc_ext          = {{(RB_W + 12 - PCW){1'b0}}, pc_r};
  assign res_status      = st_r;
  assign res_input_taken = tk_r;
  assign res_out_valid   = ov_r;
  assign res_out_value   = oval_r;
  assign res_next_pc     = pc_ext[11:0];
endmodule

@@ rtl/core/icp_checker.sv @@
// ----------------------------------------------------------------------------
// icp_checker
// Port-level checks of the Intcode step unit, bound to the top level.
// ----------------------------------------------------------------------------
module icp_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  out_status,
  input logic        out_input_taken,
  input logic        out_out_valid,
  input logic [63:0] out_out_value
);
  import icp_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) && $stable(out_out_value))
    else $error("result word dropped or changed while stalled");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second word accepted while one is in flight");

  a_side_effects_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_input_taken || out_out_valid) |-> out_status == STAT_RUN)
    else $error("input taken or output given with non-running status");

  a_value_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_out_valid |-> out_out_value == 64'd0)
    else $error("output value nonzero without output instruction");
endmodule

bind intcode_processor_step_unit icp_checker u_icp_checker (
  .clk(clk), .rst_n(rst_n),
  .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .out_status(out_ch.status), .out_input_taken(out_ch.input_taken),
  .out_out_valid(out_ch.out_valid), .out_out_value(64'(out_ch.out_value))
);

@@ dv/intcode_processor_step_unit_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// intcode_processor_step_unit_tb
// Drives load, execute, restart and spare words into the Intcode step unit and
// checks every result word against a cycle-free predictor of the machine.
// Directed programs cover each opcode and several error cases; random
// programs follow. Both channels idle at random outside the steady rounds.
// ----------------------------------------------------------------------------
module intcode_processor_step_unit_tb;
  import icp_pkg::*;

  localparam int NWORDS = 4096;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct {
    logic [1:0]  mode;
    logic [11:0] address;
    longint      data;
    logic        input_valid;
    longint      input_value;
  } cmd_t;

  typedef struct {
    logic [1:0]  status;
    logic        input_taken;
    logic        out_valid;
    longint      out_value;
    logic [11:0] next_pc;
  } res_t;

  class intcode_scoreboard;
    longint mem[NWORDS];
    int     pc;
    int     rbase;
    bit     halted;
    bit     errored;
    res_t   pending[$];
    int     mismatches;

    function new();
      foreach (mem[i]) mem[i] = 0;
      pc = 0;
      rbase = 0;
      halted = 0;
      errored = 0;
      mismatches = 0;
    endfunction

    function logic [1:0] idle_status();
      return errored ? STAT_ERR : (halted ? STAT_HALT : STAT_RUN);
    endfunction

    function void execute(cmd_t c, inout res_t r);
      int     nparams[10] = '{0, 3, 3, 1, 1, 2, 2, 3, 3, 1};
      int     op, n, npc, loc;
      int     md[4];
      int     addr[4];
      longint v[4];
      longint ins, rest, raw, sum, tgt;
      bit     bad;
      bad = 0;
      npc = pc;
      op = 0;
      md = '{0, 0, 0, 0};
      v = '{0, 0, 0, 0};
      if (pc >= NWORDS) begin
        bad = 1;
      end else begin
        ins = mem[pc];
        if (ins == longint'(HALT_WORD)) begin
          halted = 1;
          r.status = STAT_HALT;
          return;
        end
        if (ins < 0) bad = 1;
        else begin
          op = int'(ins % 100);
          rest = ins / 100;
          if (op < 1 || op > 9) bad = 1;
        end
        if (!bad) begin
          n = nparams[op];
          for (int i = 1; i <= n && !bad; i++) begin
            md[i] = int'(rest % 10);
            rest = rest / 10;
            loc = pc + i;
            if (loc >= NWORDS) begin
              bad = 1;
            end else begin
              raw = mem[loc];
              if (md[i] == PM_POS) begin
                if (raw < 0 || raw >= NWORDS) bad = 1;
                else addr[i] = int'(raw);
              end else if (md[i] == PM_IMM) begin
                addr[i] = loc;
              end else if (md[i] == PM_REL) begin
                if (raw > REL_MAX || raw < REL_MIN) bad = 1;
                else begin
                  sum = longint'(rbase) + raw;
                  if (sum < 0 || sum >= NWORDS) bad = 1;
                  else addr[i] = int'(sum);
                end
              end else begin
                bad = 1;
              end
              if (!bad) v[i] = mem[addr[i]];
            end
          end
          if (!bad && rest != 0) bad = 1;
          if (!bad && (op == OP_ADD || op == OP_MUL || op == OP_LT || op == OP_EQ) &&
              md[3] == PM_IMM) bad = 1;
          if (!bad && op == OP_IN && md[1] == PM_IMM) bad = 1;
        end
      end
      if (!bad) begin
        case (op)
          OP_ADD: begin mem[addr[3]] = v[1] + v[2]; npc += 4; end
          OP_MUL: begin mem[addr[3]] = v[1] * v[2]; npc += 4; end
          OP_IN: begin
            if (!c.input_valid) begin
              r.status = STAT_WAIT;
              return;
            end
            mem[addr[1]] = c.input_value;
            r.input_taken = 1;
            npc += 2;
          end
          OP_OUT: begin r.out_valid = 1; r.out_value = v[1]; npc += 2; end
          OP_JT, OP_JF: begin
            if ((op == OP_JT) ? (v[1] != 0) : (v[1] == 0)) begin
              tgt = v[2];
              if (tgt < 0 || tgt >= NWORDS) bad = 1;
              else npc = int'(tgt);
            end else npc += 3;
          end
          OP_LT: begin mem[addr[3]] = (v[1] < v[2]) ? 1 : 0; npc += 4; end
          OP_EQ: begin mem[addr[3]] = (v[1] == v[2]) ? 1 : 0; npc += 4; end
          default: begin rbase = rbase + int'(v[1][31:0]); npc += 2; end
        endcase
      end
      if (bad) begin
        errored = 1;
        r.status = STAT_ERR;
        r.input_taken = 0;
        r.out_valid = 0;
        r.out_value = 0;
        return;
      end
      pc = npc;
      r.status = STAT_RUN;
    endfunction

    function void note(cmd_t c);
      res_t r;
      r = '{status: STAT_RUN, input_taken: 0, out_valid: 0, out_value: 0, next_pc: 0};
      case (c.mode)
        MODE_LOAD: begin
          mem[c.address] = c.data;
          r.status = idle_status();
        end
        MODE_RESTART: begin
          pc = 0;
          rbase = 0;
          halted = 0;
          errored = 0;
          r.status = STAT_RUN;
        end
        MODE_EXEC: begin
          if (errored || halted) r.status = idle_status();
          else execute(c, r);
        end
        default: r.status = idle_status();
      endcase
      r.next_pc = pc[11:0];
      pending = {pending, r};
    endfunction

    function void check(res_t a);
      res_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result word status=%0d", $time, a.status);
        mismatches++;
        return;
      end
      e = pending.pop_front();
      if (a.status !== e.status) begin
        $display("%0t: status exp %0d got %0d", $time, e.status, a.status);
        mismatches++;
      end
      if (a.input_taken !== e.input_taken) begin
        $display("%0t: input_taken exp %0d got %0d", $time, e.input_taken, a.input_taken);
        mismatches++;
      end
      if (a.out_valid !== e.out_valid) begin
        $display("%0t: out_valid exp %0d got %0d", $time, e.out_valid, a.out_valid);
        mismatches++;
      end
      if (a.out_value !== e.out_value) begin
        $display("%0t: out_value exp %0d got %0d", $time, e.out_value, a.out_value);
        mismatches++;
      end
      if (a.next_pc !== e.next_pc) begin
        $display("%0t: next_pc exp %0d got %0d", $time, e.next_pc, a.next_pc);
        mismatches++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  int   cycles;
  bit   steady;

  icp_in_if  in_ch();
  icp_out_if out_ch();

  intcode_scoreboard sb;

  intcode_processor_step_unit uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source)
  );

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  initial begin
    in_ch.valid = 0;
    in_ch.mode = MODE_LOAD;
    in_ch.address = 0;
    in_ch.data = 0;
    in_ch.input_valid = 0;
    in_ch.input_value = 0;
    out_ch.ready = 0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  always @(negedge clk) begin
    out_ch.ready <= rst_n && (steady || $urandom_range(99) >= 26);
  end

  always @(posedge clk) begin
    res_t a;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      a.status = out_ch.status;
      a.input_taken = out_ch.input_taken;
      a.out_valid = out_ch.out_valid;
      a.out_value = out_ch.out_value;
      a.next_pc = out_ch.next_pc;
      sb.check(a);
    end
  end

  task automatic send(logic [1:0] mode, logic [11:0] address, longint data,
                      logic input_valid, longint input_value);
    cmd_t c;
    while (!steady && $urandom_range(99) < 26) begin
      @(negedge clk);
      in_ch.valid = 0;
    end
    @(negedge clk);
    in_ch.valid = 1;
    in_ch.mode = mode;
    in_ch.address = address;
    in_ch.data = data;
    in_ch.input_valid = input_valid;
    in_ch.input_value = input_value;
    do @(posedge clk); while (!in_ch.ready);
    c = '{mode, address, data, input_valid, input_value};
    sb.note(c);
    @(negedge clk);
    in_ch.valid = 0;
  endtask

  task automatic load(int address, longint data);
    send(MODE_LOAD, address[11:0], data, 0, 0);
  endtask

  task automatic step(logic input_valid, longint input_value);
    send(MODE_EXEC, 12'($urandom), {$urandom, $urandom}, input_valid, input_value);
  endtask

  function automatic longint rand_word();
    return {$urandom, $urandom};
  endfunction

  function automatic longint instr(int op, int m1, int m2, int m3);
    return op + 100 * m1 + 1000 * m2 + 10000 * m3;
  endfunction

  task automatic random_program();
    int     a, op, k;
    longint w;
    a = 0;
    while (a < 44) begin
      k = $urandom_range(99);
      if (k < 4) w = longint'(HALT_WORD);
      else if (k < 9) w = (k < 6) ? -longint'($urandom_range(500)) : $urandom_range(99999);
      else begin
        op = $urandom_range(OP_ARB, OP_ADD);
        w = instr(op, $urandom_range(PM_REL), $urandom_range(PM_REL),
                  (op == OP_IN || op == OP_ADD || op == OP_MUL || op == OP_LT ||
                   op == OP_EQ) ? $urandom_range(1) * PM_REL : $urandom_range(PM_REL));
      end
      load(a, w);
      a++;
      for (int i = 0; i < 3; i++) begin
        k = $urandom_range(99);
        if (k < 80) w = $urandom_range(63);
        else if (k < 85) w = rand_word();
        else if (k < 90) w = -longint'($urandom_range(8));
        else w = $urandom_range(43);
        load(a, w);
        a++;
      end
    end
    for (int i = 44; i < 64; i += 4) load(i, ($urandom_range(1)) ? rand_word() : $urandom_range(63));
    load($urandom, rand_word());
    if ($urandom_range(9) == 0) send(MODE_SPARE, 12'($urandom), rand_word(), 1, rand_word());
    send(MODE_RESTART, 0, 0, 0, 0);
    for (int i = 0; i < 24; i++) step($urandom_range(99) < 75, rand_word());
  endtask

  initial begin
    longint prog[32] = '{1101, 5, 7, 40, 1002, 40, 3, 41, 3, 42, 4, 42, 109, 5,
                         204, 35, 1107, 1, 2, 43, 1108, 3, 3, 44, 1105, 0, 99,
                         1106, 0, 31, 0, 99};
    longint badw[6] = '{-1, 50, 30001, 100004, 10001, 209};
    sb = new();
    cycles = 0;
    steady = 0;
    rst_n = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1;

    foreach (prog[i]) load(i, prog[i]);
    step(1, 64'sh7FFF_FFFF_FFFF_FFFF);
    step(0, 0);
    step(0, 5);
    step(1, -64'sd9223372036854775807 - 1);
    for (int i = 0; i < 10; i++) step(1, 3);
    send(MODE_SPARE, 12'hFFF, -1, 1, -1);
    for (int i = 0; i < 6; i++) begin
      send(MODE_RESTART, 0, 0, 0, 0);
      load(0, badw[i]);
      load(1, (i == 5) ? 64'sd8589934593 : 64'sd7);
      step(1, 0);
      step(1, 0);
      load(12'hFFF, 0);
    end
    send(MODE_RESTART, 0, 0, 0, 0);
    load(0, 1105);
    load(1, 1);
    load(2, 5000);
    step(0, 0);
    send(MODE_RESTART, 0, 0, 0, 0);
    load(2, 4095);
    load(4095, 1);
    step(0, 0);
    step(0, 0);

    for (int e = 0; e < 11; e++) begin
      steady = (e >= 5 && e < 7);
      random_program();
    end
    steady = 0;

    while (sb.pending.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (sb.mismatches == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end
endmodule

@@ intcode_processor_step_unit.f @@
rtl/core/icp_pkg.sv
rtl/core/icp_if.sv
rtl/core/icp_ram.sv
rtl/core/icp_ctrl.sv
rtl/core/icp_dpath.sv
rtl/core/intcode_processor_step_unit.sv
rtl/core/icp_checker.sv
dv/intcode_processor_step_unit_tb.sv
